// ----- hdl/sampling_device_register_file_core_assert.svh -----
// Assertion macros used by the checker file.
`ifndef SAMPLING_DEVICE_REGISTER_FILE_CORE_ASSERT_SVH
`define SAMPLING_DEVICE_REGISTER_FILE_CORE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off while in reset.
`define SDRF_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("sdrf check failed");

// Next-cycle implication, sampled on the rising clock edge, off while in reset.
`define SDRF_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("sdrf check failed");

`endif

// ----- hdl/sdrf_pkg.sv -----
package sdrf_pkg;

  localparam int unsigned FIFO_DEPTH_DEF = 16;

  localparam logic [31:0] MIN_PERIOD   = 32'd1000;
  localparam logic [31:0] DEVICE_ID    = 32'd1363214337;
  localparam logic [31:0] VERSION_WORD = 32'h0000_0100;
  localparam logic [31:0] RESET_PERIOD = 32'd1000000;
  localparam logic [31:0] LCG_MUL      = 32'd1103515245;
  localparam logic [31:0] LCG_INC      = 32'd12345;

  // CTRL bit positions
  localparam int CTRL_ENABLE_BIT = 0;
  localparam int CTRL_IRQ_EN_BIT = 1;
  localparam int CTRL_RESET_BIT  = 2;
  localparam int CTRL_MODE_LSB   = 4;

  // IRQSTAT cause bit positions
  localparam int CAUSE_SAMPLE_BIT  = 0;
  localparam int CAUSE_OVERRUN_BIT = 1;

  // Sample modes; the fourth code behaves as the counter
  localparam logic [1:0] MODE_SAW   = 2'd1;
  localparam logic [1:0] MODE_NOISE = 2'd2;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_TICK  = 2'd2,
    OP_IDLE  = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    REG_ID      = 4'd0,
    REG_VERSION = 4'd1,
    REG_CTRL    = 4'd2,
    REG_STATUS  = 4'd3,
    REG_PERIOD  = 4'd4,
    REG_SAMPLE  = 4'd5,
    REG_LEVEL   = 4'd6,
    REG_IRQSTAT = 4'd7,
    REG_TS_LO   = 4'd8,
    REG_TS_HI   = 4'd9,
    REG_GPO     = 4'd10,
    REG_GPI     = 4'd11,
    REG_SCRATCH = 4'd12
  } reg_t;

  typedef struct packed {
    logic       fire;
    logic       clear;
    logic [1:0] mode;
  } samp_ctrl_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        access_error;
    logic        irq_line;
    logic        from_fifo;
  } res_t;

endpackage

// ----- hdl/sdrf_ram.sv -----
module sdrf_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hdl/sdrf_sampler.sv -----
module sdrf_sampler import sdrf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  samp_ctrl_t  ctrl,
  output logic [31:0] value
);

  logic [63:0] samples_made;
  logic [31:0] lcg_state;
  logic [31:0] lcg_next;

  assign lcg_next = lcg_state * LCG_MUL + LCG_INC;

  always_comb begin
    case (ctrl.mode)
      MODE_SAW:   value = {20'd0, samples_made[11:0]};
      MODE_NOISE: value = {20'd0, lcg_next[27:16]};
      default:    value = samples_made[31:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      samples_made <= '0;
      lcg_state    <= 32'd1;
    end else if (ctrl.clear) begin
      samples_made <= '0;
    end else if (ctrl.fire) begin
      samples_made <= samples_made + 64'd1;
      if (ctrl.mode == MODE_NOISE) begin
        lcg_state <= lcg_next;
      end
    end
  end

endmodule

// ----- hdl/sdrf_regs.sv -----
module sdrf_regs import sdrf_pkg::*; #(
  parameter int unsigned FIFO_DEPTH = FIFO_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [31:0]                   cfg_wr_data,
  input  logic                          acc,
  input  op_t                           op,
  input  logic [3:0]                    idx,
  input  logic [31:0]                   wdata,
  output res_t                          res,
  output samp_ctrl_t                    samp,
  input  logic [31:0]                   samp_value,
  output logic                          ram_we,
  output logic [$clog2(FIFO_DEPTH)-1:0] ram_waddr,
  output logic [31:0]                   ram_wdata,
  output logic                          ram_re,
  output logic [$clog2(FIFO_DEPTH)-1:0] ram_raddr
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam int SUM_W = PTR_W + 1;

  logic [31:0]      ctrl, ctrl_next;
  logic [31:0]      period_value, period_value_next;
  logic [31:0]      elapsed, elapsed_next;
  logic [1:0]       causes, causes_next;
  logic             overrun, overrun_next;
  logic [7:0]       gpio, gpio_next;
  logic [31:0]      scratch, scratch_next;
  logic [PTR_W-1:0] oldest, oldest_next;
  logic [CNT_W-1:0] count, count_next;
  logic [63:0]      now_time, now_time_next;
  logic [63:0]      sample_stamp, sample_stamp_next;
  logic [63:0]      stamp_copy, stamp_copy_next;

  logic             ring_empty, fifo_full, running, period_hit;
  logic [31:0]      elapsed_inc;
  logic [63:0]      now_inc;
  logic [SUM_W-1:0] slot_sum;
  logic [PTR_W-1:0] wr_slot, oldest_wrap;

  assign ring_empty  = (count == '0);
  assign fifo_full   = (count == CNT_W'(FIFO_DEPTH));
  assign running     = ctrl[CTRL_ENABLE_BIT] && (period_value >= MIN_PERIOD);
  assign elapsed_inc = elapsed + 32'd1;
  assign period_hit  = (elapsed_inc >= period_value);
  assign now_inc     = now_time + 64'd1;

  // Ring slot arithmetic: the sum stays below twice the depth
  assign slot_sum    = {1'b0, oldest} + SUM_W'(count);
  assign wr_slot     = (slot_sum >= SUM_W'(FIFO_DEPTH)) ?
                       PTR_W'(slot_sum - SUM_W'(FIFO_DEPTH)) : PTR_W'(slot_sum);
  assign oldest_wrap = (oldest == PTR_W'(FIFO_DEPTH - 1)) ? '0 : oldest + PTR_W'(1);

  always_comb begin
    ctrl_next         = ctrl;
    period_value_next = period_value;
    elapsed_next      = elapsed;
    causes_next       = causes;
    overrun_next      = overrun;
    gpio_next         = gpio;
    scratch_next      = scratch;
    oldest_next       = oldest;
    count_next        = count;
    now_time_next     = now_time;
    sample_stamp_next = sample_stamp;
    stamp_copy_next   = stamp_copy;
    res               = '0;
    samp              = '0;
    samp.mode         = ctrl[CTRL_MODE_LSB +: 2];
    ram_we            = 1'b0;
    ram_waddr         = wr_slot;
    ram_wdata         = samp_value;
    ram_re            = 1'b0;
    ram_raddr         = oldest;
    if (acc) begin
      unique case (op)
        OP_READ: begin
          unique case (reg_t'(idx))
            REG_ID:      res.read_data = DEVICE_ID;
            REG_VERSION: res.read_data = VERSION_WORD;
            REG_CTRL:    res.read_data = ctrl;
            REG_STATUS:  res.read_data = {28'd0, overrun, fifo_full, ring_empty, 1'b1};
            REG_PERIOD:  res.read_data = period_value;
            REG_SAMPLE: begin
              if (!ring_empty) begin
                ram_re        = 1'b1;
                res.from_fifo = 1'b1;
                oldest_next   = oldest_wrap;
                count_next    = count - CNT_W'(1);
                if (count == CNT_W'(1)) begin
                  causes_next[CAUSE_SAMPLE_BIT] = 1'b0;
                end
              end
            end
            REG_LEVEL:   res.read_data = 32'(count);
            REG_IRQSTAT: res.read_data = {30'd0, causes};
            REG_TS_LO: begin
              stamp_copy_next = sample_stamp;
              res.read_data   = sample_stamp[31:0];
            end
            REG_TS_HI:   res.read_data = stamp_copy[63:32];
            REG_GPO:     res.read_data = {24'd0, gpio};
            REG_GPI:     res.read_data = {24'd0, gpio[3:0], 4'd0};
            REG_SCRATCH: res.read_data = scratch;
            default:     res.access_error = 1'b1;
          endcase
        end
        OP_WRITE: begin
          unique case (reg_t'(idx))
            REG_CTRL: begin
              if (wdata[CTRL_RESET_BIT]) begin
                oldest_next  = '0;
                count_next   = '0;
                samp.clear   = 1'b1;
                overrun_next = 1'b0;
                causes_next  = '0;
              end
              ctrl_next                 = wdata;
              ctrl_next[CTRL_RESET_BIT] = 1'b0;
              elapsed_next              = '0;
            end
            REG_PERIOD: begin
              period_value_next = wdata;
              elapsed_next      = '0;
            end
            REG_IRQSTAT: begin
              causes_next = causes & ~wdata[1:0];
              if (wdata[CAUSE_OVERRUN_BIT]) begin
                overrun_next = 1'b0;
              end
            end
            REG_GPO:     gpio_next    = wdata[7:0];
            REG_SCRATCH: scratch_next = wdata;
            default:     res.access_error = 1'b1;
          endcase
        end
        OP_TICK: begin
          now_time_next = now_inc;
          if (running) begin
            elapsed_next = elapsed_inc;
            if (period_hit) begin
              sample_stamp_next = now_inc;
              samp.fire         = 1'b1;
              elapsed_next      = '0;
              if (fifo_full) begin
                overrun_next                   = 1'b1;
                causes_next[CAUSE_OVERRUN_BIT] = 1'b1;
              end else begin
                ram_we                        = 1'b1;
                count_next                    = count + CNT_W'(1);
                causes_next[CAUSE_SAMPLE_BIT] = 1'b1;
              end
            end
          end else begin
            elapsed_next = '0;
          end
        end
        default: ;
      endcase
    end
    res.irq_line = (|causes_next) && ctrl_next[CTRL_IRQ_EN_BIT];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl         <= '0;
      period_value <= RESET_PERIOD;
      elapsed      <= '0;
      causes       <= '0;
      overrun      <= 1'b0;
      gpio         <= '0;
      scratch      <= '0;
      oldest       <= '0;
      count        <= '0;
      now_time     <= '0;
      sample_stamp <= '0;
      stamp_copy   <= '0;
    end else begin
      ctrl         <= ctrl_next;
      period_value <= period_value_next;
      elapsed      <= elapsed_next;
      causes       <= causes_next;
      overrun      <= overrun_next;
      gpio         <= gpio_next;
      scratch      <= scratch_next;
      oldest       <= oldest_next;
      count        <= count_next;
      now_time     <= now_time_next;
      sample_stamp <= sample_stamp_next;
      stamp_copy   <= stamp_copy_next;
      // Strap the period and restart the count
      if (cfg_wr_en) begin
        period_value <= cfg_wr_data;
        elapsed      <= '0;
      end
    end
  end

endmodule

// ----- hdl/sampling_device_register_file_core.sv -----
// Sampling device register file.
// Input stream (s_*): one word per register access or time tick. tdata holds
// operation [1:0], reg_index [5:2] and write_data [37:6]. Output stream (m_*):
// one result word per input word, in order: read_data [31:0],
// access_error [32], irq_line [33] (the interrupt level after the access).
// Configuration: cfg_wr_en/cfg_wr_data load the live period and restart the
// period count; the reset period itself stays fixed.
// A result shows on m_tvalid in the cycle after its input is accepted.
// Throughput: one word per cycle unless a stall holds the output; the sample
// FIFO read is registered; all other registers update in the accepting cycle.
// Reset (rst, synchronous): clears all control state and loads the period
// with its default; the sample memory needs no clearing pass.
// Stall: the result waits in the output register while m_tready is low; a
// new word is taken in the same cycle the waiting one leaves, so s_tready
// stays high while the output register is empty or being drained.
module sampling_device_register_file_core import sdrf_pkg::*; #(
  parameter int unsigned FIFO_DEPTH = FIFO_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // operation[1:0], reg_index[5:2], write_data[37:6]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // read_data[31:0], access_error[32], irq_line[33]
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);

  logic             acc;
  res_t             res;
  res_t             out_res;
  logic             out_valid;
  samp_ctrl_t       samp;
  logic [31:0]      samp_value;
  logic             ram_we, ram_re;
  logic [PTR_W-1:0] ram_waddr, ram_raddr;
  logic [31:0]      ram_wdata, ram_rdata;
  logic [31:0]      out_data;

  // Take a word while the output register is free or draining
  assign s_tready = !out_valid || m_tready;
  assign acc      = s_tvalid && s_tready;

  sdrf_regs #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_regs (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .acc         (acc),
    .op          (op_t'(s_tdata[1:0])),
    .idx         (s_tdata[5:2]),
    .wdata       (s_tdata[37:6]),
    .res         (res),
    .samp        (samp),
    .samp_value  (samp_value),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_re      (ram_re),
    .ram_raddr   (ram_raddr)
  );

  sdrf_sampler u_sampler (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (samp),
    .value (samp_value)
  );

  // Sample FIFO storage; read data only moves on a pop, so it holds under stall
  sdrf_ram #(
    .WIDTH (32),
    .DEPTH (FIFO_DEPTH)
  ) u_fifo_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Output register: hold the result until the receiver takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (acc) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      out_res <= res;
    end
  end

  // A pop takes its word from the memory's registered read port
  assign out_data = out_res.from_fifo ? ram_rdata : out_res.read_data;
  assign m_tvalid = out_valid;
  assign m_tdata  = {6'd0, out_res.irq_line, out_res.access_error, out_data};

endmodule

// ----- hdl/sdrf_checker.sv -----
module sdrf_checker import sdrf_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [39:0] s_tdata,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata
);

`include "sampling_device_register_file_core_assert.svh"

  // Stalled result holds
  `SDRF_ASSERT_NXT(a_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

  // An empty output register never blocks the input
  `SDRF_ASSERT_IMP(a_ready, clk, rst, !m_tvalid, s_tready)

  // Every accepted word yields a result in the next cycle
  `SDRF_ASSERT_NXT(a_result, clk, rst, s_tvalid && s_tready, m_tvalid)

  // A write to the ID register is refused and reads back zero
  `SDRF_ASSERT_NXT(a_ro_write, clk, rst, s_tvalid && s_tready && (s_tdata[1:0] == OP_WRITE) && (s_tdata[5:2] == REG_ID), m_tdata[32] && (m_tdata[31:0] == 32'd0))

endmodule

bind sampling_device_register_file_core sdrf_checker u_sdrf_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
